### hdl/eiec_pkg.sv
// Shared types and constants for the external interrupt edge controller.
// No dependencies; imported by the controller top level.
package eiec_pkg;

  localparam int LINE_W        = 16;  // width of every per-line field
  localparam int DEF_NUM_LINES = 16;  // default number of implemented lines
  localparam int NUM_PORTS     = 4;   // ports that a source select may name
  localparam int PORT_INPUTS   = 4;   // port level inputs on the block
  localparam int PORT_SEL_W    = $clog2(PORT_INPUTS);
  localparam int SEL_W         = 8;   // one source select field
  localparam int SEL_LIMIT     = (NUM_PORTS < PORT_INPUTS) ? NUM_PORTS : PORT_INPUTS;
  localparam int SRC_REG_W     = 32;
  localparam int SELS_PER_REG  = SRC_REG_W / SEL_W;
  localparam int CFG_IDX_W     = 3;
  localparam int LINE_IDX_W    = 4;
  localparam int GROUP_HI_LOW  = 4;   // first line of the shared 4-15 group

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_0_3      = 3'd0,
    REG_SOURCE_4_7      = 3'd1,
    REG_SOURCE_8_11     = 3'd2,
    REG_SOURCE_12_15    = 3'd3,
    REG_RISING_ENABLE   = 3'd4,
    REG_FALLING_ENABLE  = 3'd5,
    REG_INTERRUPT_EN    = 3'd6,
    REG_EVENT_ENABLE    = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_CLEAR  = 1'b1
  } req_type_t;

endpackage

### hdl/external_interrupt_edge_controller.sv
// A request accepted into stage 1 moves on into the result register once that register is empty or being taken.
// Throughput: one request per cycle; the input register feeds one pass of edge logic
// into the result register, and a stalled result backs up stage 1 and then the input.
// Reset (rst, synchronous): all configuration registers, previous levels and
// pending bits clear to zero; both pipeline stages empty.
// Depends on eiec_pkg.
module external_interrupt_edge_controller #(
  parameter int NUM_LINES = eiec_pkg::DEF_NUM_LINES
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [eiec_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [eiec_pkg::SRC_REG_W-1:0]    cfg_data,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              req_type,
  input  logic [eiec_pkg::LINE_W-1:0]       port0_levels,
  input  logic [eiec_pkg::LINE_W-1:0]       port1_levels,
  input  logic [eiec_pkg::LINE_W-1:0]       port2_levels,
  input  logic [eiec_pkg::LINE_W-1:0]       port3_levels,
  input  logic [eiec_pkg::LINE_W-1:0]       clear_rising,
  input  logic [eiec_pkg::LINE_W-1:0]       clear_falling,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [eiec_pkg::LINE_W-1:0]       rising_pending_out,
  output logic [eiec_pkg::LINE_W-1:0]       falling_pending_out,
  output logic                              irq_group_0_1,
  output logic                              irq_group_2_3,
  output logic                              irq_group_4_15,
  output logic [eiec_pkg::LINE_IDX_W-1:0]   first_line_4_15,
  output logic                              event_pulse
);
  import eiec_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; the source registers are
  // kept as one select byte per line so each line reads its own field.
  // ---------------------------------------------------------------------------
  logic [SEL_W-1:0]  line_sel [LINE_W];
  logic [LINE_W-1:0] rising_enable;
  logic [LINE_W-1:0] falling_enable;
  logic [LINE_W-1:0] interrupt_enable;
  logic [LINE_W-1:0] event_enable;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < LINE_W; l++) begin
        line_sel[l] <= '0;
      end
      rising_enable    <= '0;
      falling_enable   <= '0;
      interrupt_enable <= '0;
      event_enable     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SOURCE_0_3, REG_SOURCE_4_7, REG_SOURCE_8_11, REG_SOURCE_12_15: begin
          // four select bytes land on four consecutive lines
          for (int k = 0; k < SELS_PER_REG; k++) begin
            line_sel[{cfg_index[1:0], k[1:0]}] <= cfg_data[k*SEL_W +: SEL_W];
          end
        end
        REG_RISING_ENABLE:  rising_enable    <= cfg_data[LINE_W-1:0];
        REG_FALLING_ENABLE: falling_enable   <= cfg_data[LINE_W-1:0];
        REG_INTERRUPT_EN:   interrupt_enable <= cfg_data[LINE_W-1:0];
        REG_EVENT_ENABLE:   event_enable     <= cfg_data[LINE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. Stage 1 holds the accepted request; it moves on into the
  // result register whenever that register is empty or being taken.
  // ---------------------------------------------------------------------------
  logic s1_valid;
  logic advance;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  // Stage 1 payload: captured on every free cycle, no reset needed.
  logic              s1_req;
  logic [LINE_W-1:0] s1_port [PORT_INPUTS];
  logic [LINE_W-1:0] s1_clear_rise;
  logic [LINE_W-1:0] s1_clear_fall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_req        <= req_type;
      s1_port[0]    <= port0_levels;
      s1_port[1]    <= port1_levels;
      s1_port[2]    <= port2_levels;
      s1_port[3]    <= port3_levels;
      s1_clear_rise <= clear_rising;
      s1_clear_fall <= clear_falling;
    end
  end

  // ---------------------------------------------------------------------------
  // Edge logic: route each line to its selected port pin, find edges against
  // the previous sample, update pending bits.
  // ---------------------------------------------------------------------------
  logic [NUM_LINES-1:0] previous_levels;
  logic [NUM_LINES-1:0] rising_pending;
  logic [NUM_LINES-1:0] falling_pending;

  logic [NUM_LINES-1:0] cur_levels;
  logic [NUM_LINES-1:0] rise_edges;
  logic [NUM_LINES-1:0] fall_edges;
  logic [NUM_LINES-1:0] previous_levels_next;
  logic [NUM_LINES-1:0] rising_pending_next;
  logic [NUM_LINES-1:0] falling_pending_next;
  logic                 event_next;

  always_comb begin
    for (int l = 0; l < NUM_LINES; l++) begin
      // a select naming no existing port reads as a low pin
      cur_levels[l] = 1'b0;
      if (line_sel[l] < SEL_W'(SEL_LIMIT)) begin
        cur_levels[l] = s1_port[line_sel[l][PORT_SEL_W-1:0]][l];
      end
    end
  end

  assign rise_edges = ~previous_levels & cur_levels & rising_enable[NUM_LINES-1:0];
  assign fall_edges = previous_levels & ~cur_levels & falling_enable[NUM_LINES-1:0];

  always_comb begin
    if (req_type_t'(s1_req) == REQ_CLEAR) begin
      // clear: drop pending bits under the write-one-to-clear masks, keep levels
      previous_levels_next = previous_levels;
      rising_pending_next  = rising_pending & ~s1_clear_rise[NUM_LINES-1:0];
      falling_pending_next = falling_pending & ~s1_clear_fall[NUM_LINES-1:0];
      event_next           = 1'b0;
    end else begin
      previous_levels_next = cur_levels;
      rising_pending_next  = rising_pending | rise_edges;
      falling_pending_next = falling_pending | fall_edges;
      event_next           = |((rise_edges | fall_edges) & event_enable[NUM_LINES-1:0]);
    end
  end

  // Group outputs and the lowest pending line of the shared group.
  logic [LINE_W-1:0]     pend_next;
  logic [LINE_W-1:0]     masked_next;
  logic [LINE_IDX_W-1:0] first_next;

  assign pend_next   = LINE_W'(rising_pending_next | falling_pending_next);
  assign masked_next = pend_next & interrupt_enable;

  always_comb begin
    first_next = '0;
    // scan downward so the lowest set line wins
    for (int l = LINE_W - 1; l >= GROUP_HI_LOW; l--) begin
      if (pend_next[l]) begin
        first_next = LINE_IDX_W'(l);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // State and result register: both load together as a request leaves stage 1,
  // so the pending state always equals the pending bits shown on the output.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      previous_levels <= '0;
      rising_pending  <= '0;
      falling_pending <= '0;
    end else if (advance) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        previous_levels <= previous_levels_next;
        rising_pending  <= rising_pending_next;
        falling_pending <= falling_pending_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      irq_group_0_1   <= |masked_next[1:0];
      irq_group_2_3   <= |masked_next[3:2];
      irq_group_4_15  <= |masked_next[LINE_W-1:GROUP_HI_LOW];
      first_line_4_15 <= first_next;
      event_pulse     <= event_next;
    end
  end

  assign rising_pending_out  = LINE_W'(rising_pending);
  assign falling_pending_out = LINE_W'(falling_pending);

endmodule

### hdl/eiec_checker.sv
// Port-level checker for the external interrupt edge controller, bound to the top.
// Depends only on the top level's ports.
module eiec_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] rising_pending_out,
  input logic [15:0] falling_pending_out,
  input logic        irq_group_4_15,
  input logic [3:0]  first_line_4_15
);

  logic [15:0] pend;
  assign pend = rising_pending_out | falling_pending_out;

  // hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rising_pending_out)
      && $stable(falling_pending_out) && $stable(first_line_4_15))
    else $error("stalled result changed");

  // a reported line is inside the group and really pending
  a_first_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid && first_line_4_15 != 4'd0 |->
      first_line_4_15 >= 4'd4 && ((pend >> first_line_4_15) & 16'd1) == 16'd1)
    else $error("first line not pending");

  // no lower group line may be pending below the reported one
  a_first_lowest: assert property (@(posedge clk) disable iff (rst)
    out_valid && first_line_4_15 != 4'd0 |->
      ((pend & ((16'd1 << first_line_4_15) - 16'd1)) & 16'hFFF0) == 16'd0)
    else $error("first line not lowest");

  // group interrupt needs some pending line in the group, which a zero index denies
  a_group_irq: assert property (@(posedge clk) disable iff (rst)
    out_valid && irq_group_4_15 |-> pend[15:4] != 12'd0 && first_line_4_15 != 4'd0)
    else $error("group interrupt without pending line");

endmodule

bind external_interrupt_edge_controller eiec_checker u_eiec_checker (.*);

### tb/tb_top.sv
// Self-checking bench for the external interrupt edge controller: directed
// table then random phases, checked against an in-bench pending-bit predictor.
// Depends on eiec_pkg and external_interrupt_edge_controller.
`timescale 1ns / 100ps

module tb_top;
  import eiec_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int HOLD_CYCLES = 80;   // long receiver hold-off to back up the pipe
  localparam int HOLD_AFTER  = 150;  // results seen before the hold-off starts
  localparam int SETTLE      = 4;    // settling margin after the last result
  localparam logic [LINE_W-1:0] LINE_MASK = LINE_W'((17'd1 << DEF_NUM_LINES) - 1);

  typedef enum logic {ROW_WRITE, ROW_REQUEST} row_kind_t;
  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_t;

  typedef struct {
    req_type_t         req;
    logic [LINE_W-1:0] lvl [PORT_INPUTS];
    logic [LINE_W-1:0] clr_r;
    logic [LINE_W-1:0] clr_f;
  } req_item_t;

  typedef struct packed {
    logic [LINE_W-1:0]     rising;
    logic [LINE_W-1:0]     falling;
    logic                  g01;
    logic                  g23;
    logic                  g415;
    logic [LINE_IDX_W-1:0] first;
    logic                  evt;
  } pend_status_t;

  typedef struct {
    row_kind_t      kind;
    cfg_reg_t       idx;
    logic [31:0]    data;
    req_item_t      item;
    bit             typed_zero;  // expected status is all zero, written in directly
  } plan_row_t;

  // DUT connections; every input starts at a known value
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [SRC_REG_W-1:0]  cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  req_type = REQ_SAMPLE;
  logic [LINE_W-1:0]     port0_levels = '0;
  logic [LINE_W-1:0]     port1_levels = '0;
  logic [LINE_W-1:0]     port2_levels = '0;
  logic [LINE_W-1:0]     port3_levels = '0;
  logic [LINE_W-1:0]     clear_rising = '0;
  logic [LINE_W-1:0]     clear_falling = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [LINE_W-1:0]     rising_pending_out;
  logic [LINE_W-1:0]     falling_pending_out;
  logic                  irq_group_0_1;
  logic                  irq_group_2_3;
  logic                  irq_group_4_15;
  logic [LINE_IDX_W-1:0] first_line_4_15;
  logic                  event_pulse;

  // Predictor state: register copy, last sampled levels, pending bits
  logic [SRC_REG_W-1:0] shadow_regs [8];
  logic [LINE_W-1:0]    prev_levels = '0;
  logic [LINE_W-1:0]    rise_pend = '0;
  logic [LINE_W-1:0]    fall_pend = '0;
  logic [LINE_W-1:0]    last_lvl [PORT_INPUTS];

  pend_status_t status_due [$];  // predicted results, oldest first
  plan_row_t    plan [$];
  int           fails = 0;
  int           results_seen = 0;
  int           cycles = 0;
  int           burst_left = 0;

  // receiver pacing state
  stall_mode_t  stall_mode = STALL_NONE;
  int           mode_left = 0;
  logic [31:0]  stall_pat = '0;
  int           hold_left = 0;
  bit           held_once = 1'b0;

  external_interrupt_edge_controller u_dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .req_type            (req_type),
    .port0_levels        (port0_levels),
    .port1_levels        (port1_levels),
    .port2_levels        (port2_levels),
    .port3_levels        (port3_levels),
    .clear_rising        (clear_rising),
    .clear_falling       (clear_falling),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .rising_pending_out  (rising_pending_out),
    .falling_pending_out (falling_pending_out),
    .irq_group_0_1       (irq_group_0_1),
    .irq_group_2_3       (irq_group_2_3),
    .irq_group_4_15      (irq_group_4_15),
    .first_line_4_15     (first_line_4_15),
    .event_pulse         (event_pulse)
  );

  always #10 clk = ~clk;

  // Advance the pending-bit state by one request and return the status the
  // block should report for it.
  function automatic pend_status_t next_status(req_item_t it);
    logic [LINE_W-1:0] cur;
    logic [LINE_W-1:0] rise;
    logic [LINE_W-1:0] fall;
    logic [LINE_W-1:0] pend;
    logic [LINE_W-1:0] masked;
    logic [SEL_W-1:0]  sel;
    pend_status_t      s;
    s = '0;
    cur = '0;
    if (it.req == REQ_SAMPLE) begin
      // each line picks its pin from the port named by its source select;
      // a select past the last port reads as a low level
      for (int ln = 0; ln < LINE_W; ln++) begin
        sel = shadow_regs[ln / SELS_PER_REG][(ln % SELS_PER_REG) * SEL_W +: SEL_W];
        if (sel < SEL_LIMIT) cur[ln] = it.lvl[sel[PORT_SEL_W-1:0]][ln];
      end
      cur &= LINE_MASK;
      rise = ~prev_levels & cur & shadow_regs[REG_RISING_ENABLE][LINE_W-1:0];
      fall = prev_levels & ~cur & shadow_regs[REG_FALLING_ENABLE][LINE_W-1:0];
      rise_pend |= rise & LINE_MASK;
      fall_pend |= fall & LINE_MASK;
      s.evt = |((rise | fall) & LINE_MASK & shadow_regs[REG_EVENT_ENABLE][LINE_W-1:0]);
      prev_levels = cur;
    end else begin
      // clear: write-one-to-clear, levels ignored, previous levels kept
      rise_pend &= ~it.clr_r;
      fall_pend &= ~it.clr_f;
    end
    pend = rise_pend | fall_pend;
    masked = pend & shadow_regs[REG_INTERRUPT_EN][LINE_W-1:0];
    s.rising = rise_pend;
    s.falling = fall_pend;
    s.g01 = |masked[1:0];
    s.g23 = |masked[3:2];
    s.g415 = |masked[LINE_W-1:GROUP_HI_LOW];
    // lowest pending line of the shared group, unmasked
    for (int ln = GROUP_HI_LOW; ln < LINE_W; ln++) begin
      if (pend[ln] && s.first == '0) s.first = LINE_IDX_W'(ln);
    end
    return s;
  endfunction

  function automatic void add_write(cfg_reg_t idx, logic [31:0] data);
    plan_row_t r;
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.data = data;
    r.typed_zero = 1'b0;
    plan.push_back(r);
  endfunction

  function automatic void add_req(req_type_t req, logic [LINE_W-1:0] p0,
                                  logic [LINE_W-1:0] p1, logic [LINE_W-1:0] p2,
                                  logic [LINE_W-1:0] p3, logic [LINE_W-1:0] cr,
                                  logic [LINE_W-1:0] cf, bit typed_zero);
    plan_row_t r;
    r.kind = ROW_REQUEST;
    r.idx = REG_SOURCE_0_3;
    r.data = '0;
    r.item.req = req;
    r.item.lvl[0] = p0;
    r.item.lvl[1] = p1;
    r.item.lvl[2] = p2;
    r.item.lvl[3] = p3;
    r.item.clr_r = cr;
    r.item.clr_f = cf;
    r.typed_zero = typed_zero;
    plan.push_back(r);
  endfunction

  // Setting for one register: extremes now and then, selects mostly in range
  function automatic logic [31:0] random_setting(cfg_reg_t idx);
    logic [31:0] w;
    case ($urandom_range(0, 5))
      0: w = '0;
      1: w = '1;
      default: begin
        if (idx <= REG_SOURCE_12_15) begin
          for (int b = 0; b < SELS_PER_REG; b++) begin
            w[b * SEL_W +: SEL_W] = ($urandom_range(0, 3) != 0) ?
                SEL_W'($urandom_range(0, NUM_PORTS - 1)) : SEL_W'($urandom);
          end
        end else begin
          w = $urandom;
        end
      end
    endcase
    return w;
  endfunction

  // Random request: levels held or nudged by one pin half the time so that edges
  // stay sparse enough to read, fully random otherwise
  function automatic req_item_t random_item();
    req_item_t it;
    it.req = ($urandom_range(0, 3) == 0) ? REQ_CLEAR : REQ_SAMPLE;
    for (int p = 0; p < PORT_INPUTS; p++) begin
      case ($urandom_range(0, 3))
        0: it.lvl[p] = last_lvl[p];
        1: it.lvl[p] = last_lvl[p] ^ (LINE_W'(1) << $urandom_range(0, LINE_W - 1));
        default: it.lvl[p] = LINE_W'($urandom);
      endcase
      last_lvl[p] = it.lvl[p];
    end
    case ($urandom_range(0, 3))
      0: begin it.clr_r = '0; it.clr_f = '1; end
      1: begin it.clr_r = '1; it.clr_f = '0; end
      default: begin
        it.clr_r = LINE_W'($urandom & $urandom);
        it.clr_f = LINE_W'($urandom & $urandom);
      end
    endcase
    return it;
  endfunction

  // Write one register; valid stays up so back-to-back writes need no gap.
  // The next request or idle wait drops it.
  task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    shadow_regs[idx] = (idx >= REG_RISING_ENABLE) ? {16'h0, data[LINE_W-1:0]} : data;
  endtask

  // Offer one request, hold it until accepted, then predict and pace the sender.
  task automatic offer(req_item_t it, bit typed_zero);
    pend_status_t s;
    int gap;
    cfg_valid <= 1'b0;
    in_valid <= 1'b1;
    req_type <= it.req;
    port0_levels <= it.lvl[0];
    port1_levels <= it.lvl[1];
    port2_levels <= it.lvl[2];
    port3_levels <= it.lvl[3];
    clear_rising <= it.clr_r;
    clear_falling <= it.clr_f;
    do @(posedge clk); while (in_stall);
    s = next_status(it);
    status_due.push_back(typed_zero ? pend_status_t'('0) : s);
    // bursts of random length, separated by random gaps (sometimes none)
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Drop valid and wait for every predicted result, plus the pipe latency.
  task automatic wait_idle();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic check_status(pend_status_t want);
    if (rising_pending_out !== want.rising) begin
      $error("rising_pending_out: expected %h, got %h", want.rising, rising_pending_out);
      fails++;
    end
    if (falling_pending_out !== want.falling) begin
      $error("falling_pending_out: expected %h, got %h", want.falling, falling_pending_out);
      fails++;
    end
    if (irq_group_0_1 !== want.g01) begin
      $error("irq_group_0_1: expected %b, got %b", want.g01, irq_group_0_1);
      fails++;
    end
    if (irq_group_2_3 !== want.g23) begin
      $error("irq_group_2_3: expected %b, got %b", want.g23, irq_group_2_3);
      fails++;
    end
    if (irq_group_4_15 !== want.g415) begin
      $error("irq_group_4_15: expected %b, got %b", want.g415, irq_group_4_15);
      fails++;
    end
    if (first_line_4_15 !== want.first) begin
      $error("first_line_4_15: expected %0d, got %0d", want.first, first_line_4_15);
      fails++;
    end
    if (event_pulse !== want.evt) begin
      $error("event_pulse: expected %b, got %b", want.evt, event_pulse);
      fails++;
    end
  endtask

  // Receiver: check each accepted result against the oldest prediction, then
  // pick the next stall value. Once, while the sender is busy, hold off for a
  // long stretch so the pipe fills and in_stall has to rise.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (status_due.size() == 0) begin
        $error("result with no request outstanding");
        fails++;
      end else begin
        check_status(status_due.pop_front());
      end
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!held_once && results_seen >= HOLD_AFTER && in_valid) begin
      held_once = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 80);
        stall_pat = $urandom;
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_RANDOM: out_stall <= 1'($urandom_range(0, 1));
        default: begin
          out_stall <= stall_pat[0];
          stall_pat = {stall_pat[0], stall_pat[31:1]};
        end
      endcase
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int n;
    for (int r = 0; r < 8; r++) shadow_regs[r] = '0;
    for (int p = 0; p < PORT_INPUTS; p++) last_lvl[p] = '0;

    // Reset configuration: nothing is enabled, so every status reads zero
    add_req(REQ_SAMPLE, '1, '1, '1, '1, '0, '0, 1'b1);
    add_req(REQ_SAMPLE, '0, '0, '0, '0, '0, '0, 1'b1);
    add_req(REQ_CLEAR,  '1, '1, '1, '1, '1, '1, 1'b1);
    // Lines take ports 0-3 in turn, everything enabled; upper data bits of the
    // 16-bit registers must be dropped
    add_write(REG_SOURCE_0_3,     32'h0302_0100);
    add_write(REG_SOURCE_4_7,     32'h0302_0100);
    add_write(REG_SOURCE_8_11,    32'h0302_0100);
    add_write(REG_SOURCE_12_15,   32'h0302_0100);
    add_write(REG_RISING_ENABLE,  32'hFFFF_FFFF);
    add_write(REG_FALLING_ENABLE, 32'hFFFF_FFFF);
    add_write(REG_INTERRUPT_EN,   32'hFFFF_FFFF);
    add_write(REG_EVENT_ENABLE,   32'hFFFF_FFFF);
    add_req(REQ_SAMPLE, '1, '0, '0, '0, '0, '0, 1'b0);
    add_req(REQ_SAMPLE, '1, '1, '1, '1, '0, '0, 1'b0);
    add_req(REQ_SAMPLE, '1, '1, '1, '1, '0, '0, 1'b0);  // no edge, no event
    add_req(REQ_SAMPLE, '0, '0, '0, '0, '0, '0, 1'b0);  // every line falls
    add_req(REQ_SAMPLE, '0, '1, '0, '0, '1, '1, 1'b0);  // clear masks ignored
    add_req(REQ_CLEAR,  '1, '1, '1, '1, '1, '0, 1'b0);  // levels ignored
    add_req(REQ_CLEAR,  '0, '0, '0, '0, '0, 16'h000F, 1'b0);
    add_req(REQ_CLEAR,  '0, '0, '0, '0, '1, '1, 1'b1);
    // Out-of-range selects read low; interrupts only on line 0
    add_write(REG_SOURCE_0_3,     32'hFF80_0504);
    add_write(REG_SOURCE_4_7,     32'h0403_0201);
    add_write(REG_SOURCE_8_11,    32'h0000_0000);
    add_write(REG_SOURCE_12_15,   32'h0303_0303);
    add_write(REG_INTERRUPT_EN,   32'h0000_0001);
    add_write(REG_EVENT_ENABLE,   32'h0000_0000);
    add_req(REQ_SAMPLE, '1, '1, '1, '1, '0, '0, 1'b0);
    add_req(REQ_SAMPLE, '0, '0, '0, '0, '0, '0, 1'b0);
    add_req(REQ_SAMPLE, '0, '0, '0, 16'h8000, '0, '0, 1'b0);
    // Sparse enables: the top line alone raises an event and sets first = 15
    add_write(REG_INTERRUPT_EN,   32'h0000_000C);
    add_write(REG_RISING_ENABLE,  32'h0000_8010);
    add_write(REG_FALLING_ENABLE, 32'h0000_0000);
    add_write(REG_EVENT_ENABLE,   32'h0000_8000);
    add_req(REQ_SAMPLE, 16'h8010, 16'h8010, 16'h8010, 16'h8010, '0, '0, 1'b0);
    add_req(REQ_CLEAR,  '0, '0, '0, '0, '1, '1, 1'b0);
    add_req(REQ_SAMPLE, '0, '0, '0, '0, '0, '0, 1'b0);
    add_req(REQ_SAMPLE, '0, '0, '0, 16'h8000, '0, '0, 1'b0);
    add_write(REG_INTERRUPT_EN,   32'h0000_FFF0);
    add_write(REG_RISING_ENABLE,  32'h0000_0000);
    add_write(REG_FALLING_ENABLE, 32'h0000_FFFF);
    add_req(REQ_SAMPLE, '0, '0, '0, '0, '0, '0, 1'b0);
    add_req(REQ_CLEAR,  '0, '0, '0, '0, '1, '1, 1'b1);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Walk the table; settle the block before each group of register writes
    for (int i = 0; i < plan.size(); i++) begin
      if (plan[i].kind == ROW_WRITE) begin
        if (i == 0 || plan[i - 1].kind != ROW_WRITE) wait_idle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        offer(plan[i].item, plan[i].typed_zero);
      end
    end

    // Random phases: fresh settings for every register, then a run of requests
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      for (int r = 0; r < 8; r++) write_reg(cfg_reg_t'(r), random_setting(cfg_reg_t'(r)));
      n = $urandom_range(50, 75);
      repeat (n) offer(random_item(), 1'b0);
    end
    wait_idle();

    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
